/* design/phld_pkg.sv */
// package: shared types, constants and codes for the pose history loop detector
`timescale 1ns / 1ps
`default_nettype none

package phld_pkg;

   // fixed field widths
   localparam int COORD_BITS = 20;
   localparam int HEAD_W     = 12;
   localparam int ANG_W      = 12;
   localparam int CNT_OUT_W  = 11;
   localparam int MAG_W      = COORD_BITS + 1;
   localparam int D2_W       = 2 * MAG_W + 1;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   localparam int PATH_DEPTH_DEF = 1024;

   // heading wrap
   localparam int FULL_TURN = 3600;
   localparam int HALF_TURN = 1800;

   // request codes
   localparam logic [1:0] REQ_ADD    = 2'd0;
   localparam logic [1:0] REQ_FORCE  = 2'd1;
   localparam logic [1:0] REQ_CHECK  = 2'd2;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SPACING = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_THR   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_REACH   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_POINTS = 2'd3;

   // register reset values
   localparam logic [15:0] MIN_SPACING_RST = 16'd25;
   localparam logic [10:0] ANGLE_THR_RST   = 11'd300;
   localparam logic [19:0] MAX_REACH_RST   = 20'd50000;
   localparam logic [10:0] LOOP_POINTS_RST = 11'd12;

   typedef struct packed {
      logic [1:0]                   req_type;
      logic signed [COORD_BITS-1:0] pos_x;
      logic signed [COORD_BITS-1:0] pos_y;
      logic [HEAD_W-1:0]            heading;
   } req_pkt_type;

   typedef struct packed {
      logic                 point_added;
      logic                 loop_closed;
      logic [CNT_OUT_W-1:0] stored_count;
      logic [CNT_OUT_W-1:0] dropped_count;
   } rsp_pkt_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic [HEAD_W-1:0]            h;
   } entry_type;

   typedef struct packed {
      logic            valid;
      logic [D2_W-1:0] d2;
      logic [ANG_W-1:0] ang;
   } dist_res_type;

   typedef enum logic [1:0] {
      SK_IDLE,
      SK_SQRT,
      SK_DIV,
      SK_DONE
   } skip_state_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_PRUNE_RD,
      ST_PRUNE_WAIT,
      ST_LAST_RD,
      ST_LAST_WAIT,
      ST_PUSH,
      ST_CUR_RD,
      ST_CUR_WAIT,
      ST_SCAN_RD,
      ST_SCAN_WAIT,
      ST_SKIP,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

/* design/phld_dist.sv */
// squared distance and wrapped heading difference pipeline
`timescale 1ns / 1ps
`default_nettype none

module phld_dist
   import phld_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire entry_type                    ent,
   input  wire logic signed [COORD_BITS-1:0] ref_x,
   input  wire logic signed [COORD_BITS-1:0] ref_y,
   input  wire logic [HEAD_W-1:0]            ref_h,
   output dist_res_type                      res
);

   function automatic logic [ANG_W-1:0] ang_mag(input logic [HEAD_W-1:0] a,
                                                input logic [HEAD_W-1:0] b);
      logic signed [HEAD_W+1:0] d;
      logic signed [HEAD_W+1:0] m;
      d = $signed({2'b00, a}) - $signed({2'b00, b});
      m = d;
      if (d < 0) begin
         m = d + 14'(FULL_TURN);
         if (m < 0) begin
            m = m + 14'(FULL_TURN);
         end
      end else if (d >= 14'(FULL_TURN)) begin
         m = d - 14'(FULL_TURN);
      end
      if (m > 14'(HALF_TURN)) begin
         m = 14'(FULL_TURN) - m;
      end
      return m[ANG_W-1:0];
   endfunction

   logic             s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [MAG_W-1:0] mag_x_ff, mag_y_ff;
   logic [ANG_W-1:0] ang1_ff, ang2_ff, ang3_ff;
   logic [2*MAG_W-1:0] sq_x_ff, sq_y_ff;
   logic [D2_W-1:0]  d2_ff;

   logic signed [MAG_W-1:0] dx_in, dy_in;
   logic [MAG_W-1:0]        mag_x_in, mag_y_in;

   always_comb begin
      dx_in    = MAG_W'(ent.x) - MAG_W'(ref_x);
      dy_in    = MAG_W'(ent.y) - MAG_W'(ref_y);
      mag_x_in = dx_in[MAG_W-1] ? MAG_W'(-dx_in) : MAG_W'(dx_in);
      mag_y_in = dy_in[MAG_W-1] ? MAG_W'(-dy_in) : MAG_W'(dy_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
      mag_x_ff <= mag_x_in;
      mag_y_ff <= mag_y_in;
      ang1_ff  <= ang_mag(ent.h, ref_h);
      sq_x_ff  <= mag_x_ff * mag_x_ff;
      sq_y_ff  <= mag_y_ff * mag_y_ff;
      ang2_ff  <= ang1_ff;
      d2_ff    <= D2_W'(sq_x_ff) + D2_W'(sq_y_ff);
      ang3_ff  <= ang2_ff;
   end

   assign res.valid = s3_valid_ff;
   assign res.d2    = d2_ff;
   assign res.ang   = ang3_ff;

endmodule

`default_nettype wire

/* design/phld_skip.sv */
// skip step unit: bit-serial square root then restoring division
`timescale 1ns / 1ps
`default_nettype none

module phld_skip
   import phld_pkg::*;
#(
   localparam int SQW = D2_W + (D2_W % 2),
   localparam int RW  = SQW / 2
)
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic [D2_W-1:0] d2,
   input  wire logic [15:0]     spacing,
   input  wire logic [9:0]      half,
   output logic                 done,
   output logic [RW-1:0]        step
);

   localparam int ITW = $clog2(RW + 1);

   skip_state_type state_ff, state_in;
   logic [ITW-1:0] iter_ff, iter_in;
   logic [SQW-1:0] v_ff, v_in, r_ff, r_in, bit_ff, bit_in;
   logic [RW-1:0]  num_ff, num_in;
   logic [15:0]    rem_ff, rem_in;
   logic [SQW:0]   trial;
   logic [16:0]    tr;
   logic           last_iter;

   assign last_iter = (iter_ff == ITW'(RW - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SK_IDLE: if (start) state_in = SK_SQRT;
         SK_SQRT: if (last_iter) state_in = SK_DIV;
         SK_DIV:  if (last_iter) state_in = SK_DONE;
         SK_DONE: state_in = SK_IDLE;
         default: state_in = SK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      done = (state_ff == SK_DONE);
      if (num_ff > RW'(half)) begin
         step = num_ff - RW'(half);
      end else begin
         step = RW'(1);
      end
   end

   // datapath
   always_comb begin
      v_in   = v_ff;
      r_in   = r_ff;
      bit_in = bit_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      iter_in = iter_ff + ITW'(1);
      trial  = (SQW + 1)'(r_ff) + (SQW + 1)'(bit_ff);
      tr     = {rem_ff, num_ff[RW-1]};
      case (state_ff)
         SK_IDLE: begin
            v_in    = SQW'(d2);
            r_in    = '0;
            bit_in  = SQW'(1) << (SQW - 2);
            iter_in = '0;
         end
         SK_SQRT: begin
            if ((SQW + 1)'(v_ff) >= trial) begin
               v_in = v_ff - trial[SQW-1:0];
               r_in = (r_ff >> 1) + bit_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (last_iter) begin
               iter_in = '0;
               num_in  = r_in[RW-1:0];
               rem_in  = '0;
            end
         end
         SK_DIV: begin
            if (tr >= {1'b0, spacing}) begin
               rem_in = 16'(tr - {1'b0, spacing});
               num_in = {num_ff[RW-2:0], 1'b1};
            end else begin
               rem_in = tr[15:0];
               num_in = {num_ff[RW-2:0], 1'b0};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SK_IDLE;
      end else begin
         state_ff <= state_in;
      end
      iter_ff <= iter_in;
      v_ff    <= v_in;
      r_ff    <= r_in;
      bit_ff  <= bit_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
   end

endmodule

`default_nettype wire

/* design/pose_history_loop_detector_top.sv */
// top level: pose ring memory, request sequencer and result register
`timescale 1ns / 1ps
`default_nettype none

// sequencing: after the request transfer, a forced add passes through prepare and push; a filtered
//   add first reads and prunes the oldest poses, then compares with the last pose; a check reads the
//   current pose, then scans the entries, with a serial square root and division for each skip; the
//   pace is set by the single ring read port, the distance pipeline wait and the skip unit
// throughput: one request at a time; the next one is taken while the result waits
// reset: synchronous, active high; ring empty, registers at defaults, ring contents unset
module pose_history_loop_detector_top
   import phld_pkg::*;
#(
   parameter int PATH_DEPTH = PATH_DEPTH_DEF
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_pkt_type           req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_pkt_type                rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW  = $clog2(PATH_DEPTH);
   localparam int CW  = $clog2(PATH_DEPTH + 1);
   localparam int SQW = D2_W + (D2_W % 2);
   localparam int RW  = SQW / 2;
   localparam int LW  = (CW > 11) ? CW : 11;
   localparam int SW  = (CW > RW) ? CW : RW;
   localparam logic [CW:0] DEPTH_W = (CW + 1)'(PATH_DEPTH);

   // configuration registers
   logic [15:0] min_spacing_ff;
   logic [10:0] angle_thr_ff;
   logic [19:0] max_reach_ff;
   logic [10:0] loop_points_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_spacing_ff <= MIN_SPACING_RST;
         angle_thr_ff   <= ANGLE_THR_RST;
         max_reach_ff   <= MAX_REACH_RST;
         loop_points_ff <= LOOP_POINTS_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MIN_SPACING: min_spacing_ff <= csr_wdata[15:0];
            CSR_ANGLE_THR:   angle_thr_ff   <= csr_wdata[10:0];
            CSR_MAX_REACH:   max_reach_ff   <= csr_wdata[19:0];
            CSR_LOOP_POINTS: loop_points_ff <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   // sequencer state
   state_type     state_ff, state_in;
   req_pkt_type   req_ff, req_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] oldest_ff, oldest_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] dropped_ff, dropped_in;
   logic          added_ff, added_in;
   logic          loop_ff, loop_in;
   logic signed [COORD_BITS-1:0] ref_x_ff, ref_x_in, ref_y_ff, ref_y_in;
   logic [HEAD_W-1:0] ref_h_ff, ref_h_in;
   logic [39:0]   reach2_ff, reach2_in;
   logic [31:0]   t2_ff, t2_in;
   logic [26:0]   lt_ff, lt_in;
   logic [53:0]   lt2_ff, lt2_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_pkt_type   rsp_data_ff, rsp_data_in;

   // ring memory
   entry_type     ring_mem [PATH_DEPTH];
   entry_type     rdata_ff;
   logic [AW-1:0] raddr, waddr;
   logic          mem_re, mem_we, dist_rd;
   logic          dist_start_ff;
   logic          skip_start;

   dist_res_type  dres;
   logic          skip_done;
   logic [RW-1:0] skip_step;

   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                              input logic [CW-1:0] k);
      logic [CW:0] sum;
      sum = (CW + 1)'(base) + (CW + 1)'(k);
      if (sum >= DEPTH_W) begin
         sum = sum - DEPTH_W;
      end
      return sum[AW-1:0];
   endfunction

   // decision terms
   logic          count_zero, count_full;
   logic          prune_far, last_new, cur_similar, cur_far;
   logic          scan_stop, skip_past, spacing_zero;
   logic [CW-1:0] remaining;
   logic [AW-1:0] oldest_next;

   always_comb begin
      count_zero   = (count_ff == '0);
      count_full   = (count_ff == CW'(PATH_DEPTH));
      spacing_zero = (min_spacing_ff == '0);
      prune_far    = (dres.d2 > D2_W'(reach2_ff));
      last_new     = ((43'(dres.d2) > 43'(t2_ff)) || (dres.ang > ANG_W'(angle_thr_ff)));
      cur_similar  = (43'(dres.d2) < 43'(t2_ff)) && (dres.ang < ANG_W'(angle_thr_ff));
      cur_far      = (54'(dres.d2) > lt2_ff);
      remaining    = count_ff - idx_ff;
      scan_stop    = (idx_ff >= count_ff) || (LW'(count_ff) < LW'(loop_points_ff))
                     || (LW'(remaining) < LW'(loop_points_ff));
      skip_past    = (SW'(skip_step) >= SW'(remaining));
      oldest_next  = (oldest_ff == AW'(PATH_DEPTH - 1)) ? '0 : oldest_ff + AW'(1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:       if (req_valid) state_in = ST_PREP;
         ST_PREP: begin
            case (req_ff.req_type)
               REQ_ADD:   state_in = ST_PRUNE_RD;
               REQ_FORCE: state_in = ST_PUSH;
               REQ_CHECK: state_in = (count_ff < CW'(2)) ? ST_DONE : ST_CUR_RD;
               default:   state_in = ST_DONE;
            endcase
         end
         ST_PRUNE_RD:   state_in = count_zero ? ST_PUSH : ST_PRUNE_WAIT;
         ST_PRUNE_WAIT: if (dres.valid) state_in = prune_far ? ST_PRUNE_RD : ST_LAST_RD;
         ST_LAST_RD:    state_in = ST_LAST_WAIT;
         ST_LAST_WAIT:  if (dres.valid) state_in = last_new ? ST_PUSH : ST_DONE;
         ST_PUSH:       state_in = ST_DONE;
         ST_CUR_RD:     state_in = ST_CUR_WAIT;
         ST_CUR_WAIT:   state_in = ST_SCAN_RD;
         ST_SCAN_RD:    state_in = scan_stop ? ST_DONE : ST_SCAN_WAIT;
         ST_SCAN_WAIT: begin
            if (dres.valid) begin
               if (!spacing_zero && cur_similar) begin
                  state_in = ST_DONE;
               end else if (!spacing_zero && cur_far) begin
                  state_in = ST_SKIP;
               end else begin
                  state_in = ST_SCAN_RD;
               end
            end
         end
         ST_SKIP:       if (skip_done) state_in = skip_past ? ST_DONE : ST_SCAN_RD;
         ST_DONE:       if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready  = (state_ff == ST_IDLE);
      mem_re     = 1'b0;
      dist_rd    = 1'b0;
      mem_we     = 1'b0;
      skip_start = 1'b0;
      raddr      = oldest_ff;
      waddr      = count_full ? oldest_ff : wrap_add(oldest_ff, count_ff);
      case (state_ff)
         ST_PRUNE_RD: begin
            mem_re  = !count_zero;
            dist_rd = !count_zero;
         end
         ST_LAST_RD, ST_CUR_RD: begin
            mem_re  = 1'b1;
            dist_rd = (state_ff == ST_LAST_RD);
            raddr   = wrap_add(oldest_ff, count_ff - CW'(1));
         end
         ST_SCAN_RD: begin
            mem_re  = !scan_stop;
            dist_rd = !scan_stop;
            raddr   = wrap_add(oldest_ff, idx_ff);
         end
         ST_SCAN_WAIT: skip_start = dres.valid && !spacing_zero && !cur_similar && cur_far;
         ST_PUSH:      mem_we = 1'b1;
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      req_in       = req_ff;
      count_in     = count_ff;
      oldest_in    = oldest_ff;
      idx_in       = idx_ff;
      dropped_in   = dropped_ff;
      added_in     = added_ff;
      loop_in      = loop_ff;
      ref_x_in     = ref_x_ff;
      ref_y_in     = ref_y_ff;
      ref_h_in     = ref_h_ff;
      reach2_in    = reach2_ff;
      t2_in        = t2_ff;
      lt_in        = lt_ff;
      lt2_in       = lt2_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            req_in     = req_data;
            ref_x_in   = req_data.pos_x;
            ref_y_in   = req_data.pos_y;
            ref_h_in   = req_data.heading;
            idx_in     = '0;
            dropped_in = '0;
            added_in   = 1'b0;
            loop_in    = 1'b0;
            reach2_in  = max_reach_ff * max_reach_ff;
            t2_in      = min_spacing_ff * min_spacing_ff;
            lt_in      = loop_points_ff * min_spacing_ff;
         end
         ST_PREP:  lt2_in = lt_ff * lt_ff;
         ST_PRUNE_WAIT: begin
            if (dres.valid && prune_far) begin
               oldest_in  = oldest_next;
               count_in   = count_ff - CW'(1);
               dropped_in = dropped_ff + CW'(1);
            end
         end
         ST_PUSH: begin
            added_in = 1'b1;
            if (count_full) begin
               oldest_in = oldest_next;
            end else begin
               count_in = count_ff + CW'(1);
            end
         end
         ST_CUR_WAIT: begin
            ref_x_in = rdata_ff.x;
            ref_y_in = rdata_ff.y;
            ref_h_in = rdata_ff.h;
         end
         ST_SCAN_WAIT: begin
            if (dres.valid) begin
               if (!spacing_zero && cur_similar) begin
                  loop_in = 1'b1;
               end else if (spacing_zero || !cur_far) begin
                  idx_in = idx_ff + CW'(1);
               end
            end
         end
         ST_SKIP: if (skip_done && !skip_past) idx_in = idx_ff + CW'(skip_step);
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.point_added   = added_ff;
               rsp_data_in.loop_closed   = loop_ff;
               rsp_data_in.stored_count  = CNT_OUT_W'(count_ff);
               rsp_data_in.dropped_count = CNT_OUT_W'(dropped_ff);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         oldest_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         dist_start_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         oldest_ff     <= oldest_in;
         rsp_valid_ff  <= rsp_valid_in;
         dist_start_ff <= dist_rd;
      end
      req_ff      <= req_in;
      idx_ff      <= idx_in;
      dropped_ff  <= dropped_in;
      added_ff    <= added_in;
      loop_ff     <= loop_in;
      ref_x_ff    <= ref_x_in;
      ref_y_ff    <= ref_y_in;
      ref_h_ff    <= ref_h_in;
      reach2_ff   <= reach2_in;
      t2_ff       <= t2_in;
      lt_ff       <= lt_in;
      lt2_ff      <= lt2_in;
      rsp_data_ff <= rsp_data_in;
   end

   // ring storage, one read and one write port, registered read data
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[waddr] <= '{x: req_ff.pos_x, y: req_ff.pos_y, h: req_ff.heading};
      end
      if (mem_re) begin
         rdata_ff <= ring_mem[raddr];
      end
   end

   // distance to the reference pose for each visited entry
   phld_dist u_dist (
      .clock (clock),
      .reset (reset),
      .start (dist_start_ff),
      .ent   (rdata_ff),
      .ref_x (ref_x_ff),
      .ref_y (ref_y_ff),
      .ref_h (ref_h_ff),
      .res   (dres)
   );

   // skip step from distance over spacing
   phld_skip u_skip (
      .clock   (clock),
      .reset   (reset),
      .start   (skip_start),
      .d2      (dres.d2),
      .spacing (min_spacing_ff),
      .half    (loop_points_ff[10:1]),
      .done    (skip_done),
      .step    (skip_step)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* sim/pose_history_loop_detector_top_test.sv */
// testbench: pose history loop detector checked against its own pose ring predictor
`timescale 1ns / 1ps

class pose_ring_score;
   localparam int DEPTH = phld_pkg::PATH_DEPTH_DEF;

   // predicted pose ring and registers
   longint ring_x[DEPTH];
   longint ring_y[DEPTH];
   int     ring_h[DEPTH];
   int     oldest;
   int     held;
   longint spacing, angle_thr, reach, loop_pts;
   phld_pkg::rsp_pkt_type answer_q[$];
   int     errors;

   function new();
      oldest    = 0;
      held      = 0;
      spacing   = phld_pkg::MIN_SPACING_RST;
      angle_thr = phld_pkg::ANGLE_THR_RST;
      reach     = phld_pkg::MAX_REACH_RST;
      loop_pts  = phld_pkg::LOOP_POINTS_RST;
      errors    = 0;
   endfunction

   function void set_register(logic [1:0] idx, logic [19:0] v);
      case (idx)
         phld_pkg::CSR_MIN_SPACING: spacing   = v[15:0];
         phld_pkg::CSR_ANGLE_THR:   angle_thr = v[10:0];
         phld_pkg::CSR_MAX_REACH:   reach     = v[19:0];
         default:                   loop_pts  = v[10:0];
      endcase
   endfunction

   function int slot(longint k);
      return int'((oldest + k) % DEPTH);
   endfunction

   function longint axis_sq(longint a, longint b);
      longint d;
      d = a - b;
      if (d < 0) d = -d;
      return d * d;
   endfunction

   function longint dist2(int pos, longint x, longint y);
      return axis_sq(ring_x[pos], x) + axis_sq(ring_y[pos], y);
   endfunction

   function longint heading_gap(int a, int b);
      int d, m;
      d = a - b;
      m = ((d % phld_pkg::FULL_TURN) + phld_pkg::FULL_TURN) % phld_pkg::FULL_TURN;
      if (m > phld_pkg::HALF_TURN) m = phld_pkg::FULL_TURN - m;
      return m;
   endfunction

   function longint int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function void store_pose(longint x, longint y, int h);
      int pos;
      if (held < DEPTH) begin
         pos  = slot(held);
         held = held + 1;
      end else begin
         pos    = oldest;
         oldest = (oldest + 1) % DEPTH;
      end
      ring_x[pos] = x;
      ring_y[pos] = y;
      ring_h[pos] = h;
   endfunction

   function bit loop_found();
      longint idx, d2, stp, q;
      int cur, pos;
      if (held < 2) return 0;
      cur = slot(held - 1);
      idx = 0;
      while (idx < held) begin
         stp = 1;
         if (held < loop_pts || held - idx < loop_pts) break;
         pos = slot(idx);
         d2  = dist2(pos, ring_x[cur], ring_y[cur]);
         if (spacing != 0) begin
            if (d2 < spacing * spacing &&
                heading_gap(ring_h[pos], ring_h[cur]) < angle_thr)
               return 1;
            if (d2 > (loop_pts * spacing) * (loop_pts * spacing)) begin
               q   = int_sqrt(d2) / spacing;
               stp = (q > loop_pts / 2) ? q - loop_pts / 2 : 0;
               if (stp < 1) stp = 1;
            end
         end
         idx = idx + stp;
      end
      return 0;
   endfunction

   function void note_request(phld_pkg::req_pkt_type r);
      phld_pkg::rsp_pkt_type a;
      longint x, y;
      int h, last;
      x = longint'($signed(r.pos_x));
      y = longint'($signed(r.pos_y));
      h = int'(r.heading);
      a = '0;
      case (r.req_type)
         phld_pkg::REQ_FORCE: begin
            store_pose(x, y, h);
            a.point_added = 1'b1;
         end
         phld_pkg::REQ_ADD: begin
            while (held > 0 && dist2(oldest, x, y) > reach * reach) begin
               oldest = (oldest + 1) % DEPTH;
               held   = held - 1;
               a.dropped_count = a.dropped_count + 1'b1;
            end
            if (held == 0) begin
               a.point_added = 1'b1;
            end else begin
               last = slot(held - 1);
               if (dist2(last, x, y) > spacing * spacing ||
                   heading_gap(ring_h[last], h) > angle_thr)
                  a.point_added = 1'b1;
            end
            if (a.point_added) store_pose(x, y, h);
         end
         phld_pkg::REQ_CHECK: a.loop_closed = loop_found();
         default: ;
      endcase
      a.stored_count = held[10:0];
      answer_q.push_back(a);
   endfunction

   function void field_check(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         errors = errors + 1;
      end
   endfunction

   function void check_result(phld_pkg::rsp_pkt_type r);
      phld_pkg::rsp_pkt_type w;
      if (answer_q.size() == 0) begin
         $display("%0t: unexpected result, expected none actual %h", $time, r);
         errors = errors + 1;
         return;
      end
      w = answer_q[0];
      answer_q.delete(0);
      field_check("point_added", w.point_added, r.point_added);
      field_check("loop_closed", w.loop_closed, r.loop_closed);
      field_check("stored_count", w.stored_count, r.stored_count);
      field_check("dropped_count", w.dropped_count, r.dropped_count);
   endfunction
endclass

module pose_history_loop_detector_top_test;
   import phld_pkg::*;

   localparam int STALL_LIMIT = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_pkt_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_pkt_type rsp_data;
   logic        csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_MIN_SPACING;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   pose_ring_score score = new();

   // random walk of the robot, kept close so adds, prunes and loops all happen
   longint walk_x = 0, walk_y = 0;
   int     walk_h = 0;
   int     walk_span = 30;
   bit     steady = 1'b0;   // no idling on either side while set
   int     quiet_cycles = 0;

   always #4 clock = ~clock;

   pose_history_loop_detector_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // monitor: note requests first so a same-edge result finds its answer
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) score.note_request(req_data);
         if (rsp_valid && rsp_ready) score.check_result(rsp_data);
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      rsp_ready <= !reset && (steady || $urandom_range(99) >= 34);
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // one request transfer, entered and left at a falling edge
   task automatic send_request(input req_pkt_type p);
      while (!steady && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_pose(input logic [1:0] kind, input longint x, input longint y,
                            input int h);
      req_pkt_type p;
      p.req_type = kind;
      p.pos_x    = x[COORD_BITS-1:0];
      p.pos_y    = y[COORD_BITS-1:0];
      p.heading  = h[HEAD_W-1:0];
      send_request(p);
   endtask

   // register write; the block is idle whenever this runs
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v[CSR_DATA_W-1:0];
      score.set_register(idx, v[CSR_DATA_W-1:0]);
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (score.answer_q.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_all(input int sp, input int ang, input int rch, input int pts);
      wait_drained();
      write_reg(CSR_MIN_SPACING, sp);
      write_reg(CSR_ANGLE_THR, ang);
      write_reg(CSR_MAX_REACH, rch);
      write_reg(CSR_LOOP_POINTS, pts);
   endtask

   // mostly walk steps with random kind, some returns to the start for loops,
   // some wild poses over the full field range
   task automatic random_items(input int n);
      int pick;
      logic [1:0] kind;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         kind = (pick < 45) ? REQ_ADD : (pick < 60) ? REQ_FORCE :
                (pick < 92) ? REQ_CHECK : REQ_UNUSED;
         steady = (i >= n / 3) && (i < n / 3 + n / 6);
         walk_x = walk_x + $urandom_range(2 * walk_span) - walk_span;
         walk_y = walk_y + $urandom_range(2 * walk_span) - walk_span;
         walk_h = (walk_h + $urandom_range(200)) % FULL_TURN;
         if ($urandom_range(19) == 0) begin
            walk_x = 0;
            walk_y = 0;
         end
         if ($urandom_range(9) == 0)
            send_pose(2'($urandom_range(3)), longint'($urandom), longint'($urandom),
                      int'($urandom_range(4095)));
         else if ($urandom_range(14) == 0)
            send_pose(kind, walk_x, walk_y, int'($urandom_range(4095)));
         else
            send_pose(kind, walk_x, walk_y, walk_h);
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty ring, extremes, every request kind, heading wrap
      send_pose(REQ_CHECK, 0, 0, 0);
      send_pose(REQ_ADD, -524288, -524288, 0);
      send_pose(REQ_CHECK, 0, 0, 0);
      send_pose(REQ_ADD, 524287, 524287, 3599);
      send_pose(REQ_FORCE, 524287, 524287, 3599);
      send_pose(REQ_ADD, 524287, 524287, 3599);
      send_pose(REQ_ADD, 524280, 524287, 4095);
      send_pose(REQ_ADD, 524280, 524287, 295);
      send_pose(REQ_UNUSED, -1, -1, 4095);
      send_pose(REQ_FORCE, 0, 0, 0);
      for (int i = 0; i < 12; i++) send_pose(REQ_FORCE, i, 0, 10 * i);
      send_pose(REQ_CHECK, 0, 0, 0);
      send_pose(REQ_ADD, 60000, 0, 0);
      send_pose(REQ_CHECK, 0, 0, 0);

      walk_span = 30;
      random_items(150);

      // loosest setting: a run of forced adds with a check now and then
      set_all(1, 1800, 1048575, 1);
      walk_span = 5;
      for (int i = 0; i < 60; i++) begin
         steady = (i % 30) < 10;
         walk_x = walk_x + $urandom_range(10) - 5;
         send_pose((i % 13 == 12) ? REQ_CHECK : REQ_FORCE, walk_x, walk_y,
                   int'($urandom_range(3599)));
      end
      steady = 1'b0;
      random_items(100);

      // tightest setting: short loops need the whole ring
      set_all(65535, 1, 1, 1024);
      walk_span = 50;
      random_items(80);

      set_all(40, 150, 3000, 4);
      walk_span = 60;
      random_items(150);

      wait_drained();
      repeat (50) @(negedge clock);
      if (score.errors == 0 && score.answer_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         if (score.answer_q.size() != 0)
            $display("%0t: results missing, expected %0d more actual 0", $time,
                     score.answer_q.size());
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
